/* design/nns_pkg.sv */
// Shared types and constants for the nearest-neighbor scaler.
// Holds the controller state enum, command/status structs, field widths,
// register indexes and luma coefficients. No dependencies.
`timescale 1ns / 1ps

package nns_pkg;

    // Field widths
    localparam int COORD_W   = 15;
    localparam int SRC_DIM_W = 9;
    localparam int DST_DIM_W = 15;
    localparam int PIX_W     = 8;
    localparam int WORD_W    = 4 * PIX_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE  = 3'd4;

    localparam logic [SRC_DIM_W-1:0] SRC_DIM_RESET = 9'd256;
    localparam logic [DST_DIM_W-1:0] DST_DIM_RESET = 15'd256;

    // Item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // Width used to compare a source size against the store limits (up to 4096)
    localparam int SIZE_CMP_W = 13;

    // Serial divider: product of coordinate and source size, quotient below 512
    localparam int PROD_W    = COORD_W + SRC_DIM_W;
    localparam int QUOT_W    = SRC_DIM_W;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'(QUOT_W - 1);

    // Luma coefficients, unsigned 0.16 fractions
    localparam int COEF_W     = 16;
    localparam int LUMA_PR_W  = COEF_W + PIX_W;
    localparam int LUMA_SUM_W = LUMA_PR_W + 2;
    localparam logic [COEF_W-1:0] LUMA_R = 16'd19588;
    localparam logic [COEF_W-1:0] LUMA_G = 16'd38470;
    localparam logic [COEF_W-1:0] LUMA_B = 16'd7471;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_X,
        ST_NEXT_Y,
        ST_DIV_Y,
        ST_READ,
        ST_LUMA,
        ST_FINISH
    } nns_state_t;

    typedef struct packed {
        logic capture;
        logic check;
        logic load_write;
        logic start_x;
        logic start_y;
        logic div_step;
        logic mem_read;
        logic luma;
        logic out_load;
    } nns_cmd_t;

    typedef struct packed {
        logic is_fetch;
        logic load_ok;
        logic fetch_oob;
        logic div_last;
    } nns_status_t;

endpackage

/* design/nns_dpath.sv */
// Datapath of the nearest-neighbor scaler: config registers, item capture,
// serial divider, frame store, luma products and output payload registers.
// Depends on nns_pkg; driven by commands from nns_ctrl.
`timescale 1ns / 1ps

module nns_dpath #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write
    input  logic                          cfg_we,
    input  logic [nns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nns_pkg::CFG_DATA_W-1:0] cfg_data,
    // input payload
    input  logic                          cmd,
    input  logic [nns_pkg::COORD_W-1:0]    pos_x,
    input  logic [nns_pkg::COORD_W-1:0]    pos_y,
    input  logic [nns_pkg::PIX_W-1:0]      in_red,
    input  logic [nns_pkg::PIX_W-1:0]      in_green,
    input  logic [nns_pkg::PIX_W-1:0]      in_blue,
    input  logic [nns_pkg::PIX_W-1:0]      in_alpha,
    // control
    input  nns_pkg::nns_cmd_t              ctl,
    output nns_pkg::nns_status_t           status,
    // output payload
    output logic [nns_pkg::PIX_W-1:0]      out_red,
    output logic [nns_pkg::PIX_W-1:0]      out_green,
    output logic [nns_pkg::PIX_W-1:0]      out_blue,
    output logic [nns_pkg::PIX_W-1:0]      out_alpha,
    output logic                          range_error
);

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic [nns_pkg::SRC_DIM_W-1:0] src_width_reg;
    logic [nns_pkg::SRC_DIM_W-1:0] src_height_reg;
    logic [nns_pkg::DST_DIM_W-1:0] dst_width_reg;
    logic [nns_pkg::DST_DIM_W-1:0] dst_height_reg;
    logic                          gray_mode_reg;

    // Captured item
    logic                          cmd_reg;
    logic [nns_pkg::COORD_W-1:0]   px_reg;
    logic [nns_pkg::COORD_W-1:0]   py_reg;
    logic [nns_pkg::WORD_W-1:0]    word_reg;
    logic                          err_reg;

    // Divider
    logic [nns_pkg::DST_DIM_W-1:0] div_rem_reg;
    logic [nns_pkg::DST_DIM_W-1:0] div_d_reg;
    logic [nns_pkg::QUOT_W-1:0]    div_q_reg;
    logic [nns_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [nns_pkg::QUOT_W-1:0]    qx_reg;

    // Store and luma
    logic [nns_pkg::WORD_W-1:0]    mem [DEPTH];
    logic [nns_pkg::WORD_W-1:0]    rd_data_reg;
    logic [nns_pkg::LUMA_PR_W-1:0] pr_reg;
    logic [nns_pkg::LUMA_PR_W-1:0] pg_reg;
    logic [nns_pkg::LUMA_PR_W-1:0] pb_reg;

    logic [nns_pkg::SRC_DIM_W-1:0]  sw_eff;
    logic [nns_pkg::SRC_DIM_W-1:0]  sh_eff;
    logic [nns_pkg::COORD_W-1:0]    mul_a;
    logic [nns_pkg::SRC_DIM_W-1:0]  mul_b;
    logic [nns_pkg::PROD_W-1:0]     prod;
    logic [nns_pkg::DST_DIM_W:0]    trial;
    logic                           trial_ge;
    logic [AW-1:0]                  load_addr;
    logic [AW-1:0]                  fetch_addr;
    logic [nns_pkg::LUMA_SUM_W-1:0] luma_sum;
    logic [nns_pkg::PIX_W-1:0]      luma;

    // Apply configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= nns_pkg::SRC_DIM_RESET;
            src_height_reg <= nns_pkg::SRC_DIM_RESET;
            dst_width_reg  <= nns_pkg::DST_DIM_RESET;
            dst_height_reg <= nns_pkg::DST_DIM_RESET;
            gray_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nns_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[nns_pkg::SRC_DIM_W-1:0];
                nns_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_data[nns_pkg::SRC_DIM_W-1:0];
                nns_pkg::CFG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                nns_pkg::CFG_DST_HEIGHT: dst_height_reg <= cfg_data;
                nns_pkg::CFG_GRAY_MODE:  gray_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp source sizes to 1..store limits
    always_comb
    begin
        if (src_width_reg == '0)
            sw_eff = nns_pkg::SRC_DIM_W'(1);
        else if ({4'b0, src_width_reg} > nns_pkg::SIZE_CMP_W'(MAX_SRC_WIDTH))
            sw_eff = nns_pkg::SRC_DIM_W'(MAX_SRC_WIDTH);
        else
            sw_eff = src_width_reg;

        if (src_height_reg == '0)
            sh_eff = nns_pkg::SRC_DIM_W'(1);
        else if ({4'b0, src_height_reg} > nns_pkg::SIZE_CMP_W'(MAX_SRC_HEIGHT))
            sh_eff = nns_pkg::SRC_DIM_W'(MAX_SRC_HEIGHT);
        else
            sh_eff = src_height_reg;
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= cmd;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            word_reg <= {in_alpha, in_blue, in_green, in_red};
        end
    end

    // Status toward the controller
    always_comb
    begin
        status.is_fetch  = (cmd_reg == nns_pkg::CMD_FETCH);
        status.load_ok   = (px_reg < {6'b0, sw_eff}) && (py_reg < {6'b0, sh_eff});
        status.fetch_oob = (px_reg >= dst_width_reg) || (py_reg >= dst_height_reg);
        status.div_last  = (div_cnt_reg == nns_pkg::DIV_LAST);
    end

    // Range flag for the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_reg <= 1'b0;
        else if (ctl.check)
            err_reg <= status.fetch_oob;
    end

    // Scale product for the column or the row
    assign mul_a = ctl.start_y ? py_reg : px_reg;
    assign mul_b = ctl.start_y ? sh_eff : sw_eff;
    assign prod  = nns_pkg::PROD_W'(mul_a) * nns_pkg::PROD_W'(mul_b);

    // Restoring division step, one quotient bit per cycle
    assign trial    = {div_rem_reg, div_q_reg[nns_pkg::QUOT_W-1]};
    assign trial_ge = (trial >= {1'b0, div_d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (ctl.start_x || ctl.start_y)
            div_cnt_reg <= '0;
        else if (ctl.div_step)
            div_cnt_reg <= div_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start_x || ctl.start_y)
        begin
            // quotient stays below 512, so the upper bits start below the divisor
            div_rem_reg <= prod[nns_pkg::PROD_W-1:nns_pkg::QUOT_W];
            div_q_reg   <= prod[nns_pkg::QUOT_W-1:0];
            div_d_reg   <= ctl.start_y ? dst_height_reg : dst_width_reg;
        end
        else if (ctl.div_step)
        begin
            div_rem_reg <= trial_ge ? nns_pkg::DST_DIM_W'(trial - {1'b0, div_d_reg})
                                    : trial[nns_pkg::DST_DIM_W-1:0];
            div_q_reg   <= {div_q_reg[nns_pkg::QUOT_W-2:0], trial_ge};
        end
    end

    // Hold the source column while the row divides
    always_ff @(posedge clk)
    begin
        if (ctl.start_y)
            qx_reg <= div_q_reg;
    end

    // Store addresses: row * MAX_SRC_WIDTH + column
    assign load_addr  = AW'(py_reg) * AW'(MAX_SRC_WIDTH) + AW'(px_reg);
    assign fetch_addr = AW'(div_q_reg) * AW'(MAX_SRC_WIDTH) + AW'(qx_reg);

    // Frame store write port
    always_ff @(posedge clk)
    begin
        if (ctl.load_write)
            mem[load_addr] <= word_reg;
    end

    // Frame store read port, registered
    always_ff @(posedge clk)
    begin
        if (ctl.mem_read)
            rd_data_reg <= mem[fetch_addr];
    end

    // Luma products, one register stage
    always_ff @(posedge clk)
    begin
        if (ctl.luma)
        begin
            pr_reg <= nns_pkg::LUMA_PR_W'(nns_pkg::LUMA_R) * nns_pkg::LUMA_PR_W'(rd_data_reg[7:0]);
            pg_reg <= nns_pkg::LUMA_PR_W'(nns_pkg::LUMA_G) * nns_pkg::LUMA_PR_W'(rd_data_reg[15:8]);
            pb_reg <= nns_pkg::LUMA_PR_W'(nns_pkg::LUMA_B) * nns_pkg::LUMA_PR_W'(rd_data_reg[23:16]);
        end
    end

    assign luma_sum = nns_pkg::LUMA_SUM_W'(pr_reg) + nns_pkg::LUMA_SUM_W'(pg_reg)
                    + nns_pkg::LUMA_SUM_W'(pb_reg);
    assign luma     = luma_sum[23:16];

    // Output payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            if (err_reg)
            begin
                out_red   <= '0;
                out_green <= '0;
                out_blue  <= '0;
                out_alpha <= '0;
            end
            else if (gray_mode_reg)
            begin
                out_red   <= luma;
                out_green <= luma;
                out_blue  <= luma;
                out_alpha <= rd_data_reg[31:24];
            end
            else
            begin
                out_red   <= rd_data_reg[7:0];
                out_green <= rd_data_reg[15:8];
                out_blue  <= rd_data_reg[23:16];
                out_alpha <= rd_data_reg[31:24];
            end
            range_error <= err_reg;
        end
    end

endmodule

/* design/nns_ctrl.sv */
// Controller of the nearest-neighbor scaler: sequences capture, range
// check, the two serial divisions, store read, luma and result handoff.
// Depends on nns_pkg; commands nns_dpath.
`timescale 1ns / 1ps

module nns_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  nns_pkg::nns_status_t status,
    output nns_pkg::nns_cmd_t    ctl
);

    nns_pkg::nns_state_t state_reg;
    nns_pkg::nns_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nns_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nns_pkg::ST_IDLE:
                if (in_valid)
                    state_next = nns_pkg::ST_CHECK;
            nns_pkg::ST_CHECK:
                if (!status.is_fetch)
                    state_next = nns_pkg::ST_IDLE;
                else if (status.fetch_oob)
                    state_next = nns_pkg::ST_FINISH;
                else
                    state_next = nns_pkg::ST_DIV_X;
            nns_pkg::ST_DIV_X:
                if (status.div_last)
                    state_next = nns_pkg::ST_NEXT_Y;
            nns_pkg::ST_NEXT_Y:
                state_next = nns_pkg::ST_DIV_Y;
            nns_pkg::ST_DIV_Y:
                if (status.div_last)
                    state_next = nns_pkg::ST_READ;
            nns_pkg::ST_READ:
                state_next = nns_pkg::ST_LUMA;
            nns_pkg::ST_LUMA:
                state_next = nns_pkg::ST_FINISH;
            nns_pkg::ST_FINISH:
                if (!out_valid_reg || out_ready)
                    state_next = nns_pkg::ST_IDLE;
            default:
                state_next = nns_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            nns_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
            end
            nns_pkg::ST_CHECK:
            begin
                ctl.check      = 1'b1;
                ctl.load_write = !status.is_fetch && status.load_ok;
                ctl.start_x    = status.is_fetch && !status.fetch_oob;
            end
            nns_pkg::ST_DIV_X:  ctl.div_step = 1'b1;
            nns_pkg::ST_NEXT_Y: ctl.start_y  = 1'b1;
            nns_pkg::ST_DIV_Y:  ctl.div_step = 1'b1;
            nns_pkg::ST_READ:   ctl.mem_read = 1'b1;
            nns_pkg::ST_LUMA:   ctl.luma     = 1'b1;
            nns_pkg::ST_FINISH: ctl.out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    // Result valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while a beat waits");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == nns_pkg::ST_CHECK))
        else $error("accepted beat did not reach the range check");

    a_div_x_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nns_pkg::ST_DIV_X && status.div_last) |=>
            (state_reg == nns_pkg::ST_NEXT_Y))
        else $error("column division did not hand over to row division");

    a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_write |-> (status.load_ok && !status.is_fetch))
        else $error("store written by an out-of-range or fetch beat");
`endif

endmodule

/* design/nearest_neighbor_scaler_gray.sv */
// Top level of the nearest-neighbor scaler with luma grayscale mode.
// Usage notes follow. Instantiates nns_ctrl and nns_dpath; depends on nns_pkg.
//
// Channels: an input channel (in_valid/in_ready) carries load or fetch beats,
// an output channel (out_valid/out_ready) returns one result per fetch, and a
// config channel (cfg_valid/cfg_ready, cfg_index, cfg_data), always ready,
// writes the size and gray-mode registers; the user must see it is used only
// while idle, which the block does not enforce. A load writes one RGBA pixel
// into the frame store and returns nothing; it occupies the block through
// the check state. A fetch runs a range check, two 9-step serial divisions
// on one shared divider, a store read and a luma stage, then hands its
// result to the output register from the finish state; a new beat is taken
// only back in idle, after the fetch is done. Out-of-range fetches skip the
// divider and go from check to finish. The serial divider sets the fetch rate.
// Reset clears the controller and config registers; the frame store is not
// cleared, and an entry must be loaded before it is fetched.
// While the receiver stalls, the result holds in the output register; the
// next item is still accepted and worked on, and waits at the handoff
// until the register is free.
`timescale 1ns / 1ps

module nearest_neighbor_scaler_gray #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nns_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [nns_pkg::COORD_W-1:0]    pos_x,
    input  logic [nns_pkg::COORD_W-1:0]    pos_y,
    input  logic [nns_pkg::PIX_W-1:0]      in_red,
    input  logic [nns_pkg::PIX_W-1:0]      in_green,
    input  logic [nns_pkg::PIX_W-1:0]      in_blue,
    input  logic [nns_pkg::PIX_W-1:0]      in_alpha,
    // results
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nns_pkg::PIX_W-1:0]      out_red,
    output logic [nns_pkg::PIX_W-1:0]      out_green,
    output logic [nns_pkg::PIX_W-1:0]      out_blue,
    output logic [nns_pkg::PIX_W-1:0]      out_alpha,
    output logic                          range_error
);

    nns_pkg::nns_cmd_t    ctl;
    nns_pkg::nns_status_t status;
    logic                 cfg_we;

    // Config writes are taken at any time
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    nns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .ctl       (ctl)
    );

    nns_dpath #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .in_red      (in_red),
        .in_green    (in_green),
        .in_blue     (in_blue),
        .in_alpha    (in_alpha),
        .ctl         (ctl),
        .status      (status),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .range_error (range_error)
    );

endmodule

/* sim/tb_nearest_neighbor_scaler_gray.sv */
// Self-checking testbench for nearest_neighbor_scaler_gray: a directed table, then
// randomized load/fetch traffic scored against an in-bench resampling model.
// Depends on nns_pkg and the scaler RTL; reads no files.
`timescale 1ns / 1ps

module tb_nearest_neighbor_scaler_gray;

    localparam int unsigned SRC_MAX_W = 256;
    localparam int unsigned SRC_MAX_H = 256;
    localparam int unsigned COORD_TOP = 32767;
    localparam int unsigned LUMA_COEF_R = 19588;
    localparam int unsigned LUMA_COEF_G = 38470;
    localparam int unsigned LUMA_COEF_B = 7471;
    localparam int CFG_SETTLE_CYCLES = 30;
    localparam int END_SETTLE_CYCLES = 40;
    localparam int RUN_LIMIT_NS = 2_000_000;

    // Register indexes past the last real register
    localparam logic [nns_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [nns_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [nns_pkg::PIX_W-1:0] red;
        logic [nns_pkg::PIX_W-1:0] green;
        logic [nns_pkg::PIX_W-1:0] blue;
        logic [nns_pkg::PIX_W-1:0] alpha;
        logic                      oob;
    } scaled_pixel_t;

    localparam scaled_pixel_t OOB_PIXEL = {32'h0, 1'b1};

    typedef enum logic {ROW_REG, ROW_BEAT} row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [nns_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [nns_pkg::CFG_DATA_W-1:0] reg_data;
        logic                           beat_cmd;
        logic [nns_pkg::COORD_W-1:0]    x;
        logic [nns_pkg::COORD_W-1:0]    y;
        logic [nns_pkg::WORD_W-1:0]     pixel;
        logic                           typed;
        scaled_pixel_t                  want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [nns_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [nns_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd = nns_pkg::CMD_LOAD;
    logic [nns_pkg::COORD_W-1:0] pos_x = '0;
    logic [nns_pkg::COORD_W-1:0] pos_y = '0;
    logic [nns_pkg::PIX_W-1:0] in_red = '0;
    logic [nns_pkg::PIX_W-1:0] in_green = '0;
    logic [nns_pkg::PIX_W-1:0] in_blue = '0;
    logic [nns_pkg::PIX_W-1:0] in_alpha = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [nns_pkg::PIX_W-1:0] out_red;
    logic [nns_pkg::PIX_W-1:0] out_green;
    logic [nns_pkg::PIX_W-1:0] out_blue;
    logic [nns_pkg::PIX_W-1:0] out_alpha;
    logic range_error;

    // Mirror of the block's registers and source frame
    logic [nns_pkg::SRC_DIM_W-1:0] reg_src_w = nns_pkg::SRC_DIM_RESET;
    logic [nns_pkg::SRC_DIM_W-1:0] reg_src_h = nns_pkg::SRC_DIM_RESET;
    logic [nns_pkg::DST_DIM_W-1:0] reg_dst_w = nns_pkg::DST_DIM_RESET;
    logic [nns_pkg::DST_DIM_W-1:0] reg_dst_h = nns_pkg::DST_DIM_RESET;
    logic                          reg_gray = 1'b0;
    logic [nns_pkg::WORD_W-1:0]    src_frame [SRC_MAX_W*SRC_MAX_H];
    bit                            src_written [SRC_MAX_W*SRC_MAX_H];

    scaled_pixel_t pending_pixels [$];
    dir_row_t      dir_rows [$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned n_loads = 0;
    int unsigned n_fetches = 0;
    int unsigned n_oob = 0;
    int unsigned n_reg_writes = 0;
    int unsigned n_phases = 0;

    nearest_neighbor_scaler_gray #(
        .MAX_SRC_WIDTH  (SRC_MAX_W),
        .MAX_SRC_HEIGHT (SRC_MAX_H)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .in_red      (in_red),
        .in_green    (in_green),
        .in_blue     (in_blue),
        .in_alpha    (in_alpha),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .range_error (range_error)
    );

    always #2 clk = ~clk;

    // Clamp a programmed source size into the range the store can hold
    function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned lim);
        if (raw < 1)
            return 1;
        if (raw > lim)
            return lim;
        return raw;
    endfunction

    // Expected result of a fetch at destination (dx, dy) under the current setup
    function automatic scaled_pixel_t resample_pixel(input logic [nns_pkg::COORD_W-1:0] dx,
                                                     input logic [nns_pkg::COORD_W-1:0] dy);
        scaled_pixel_t px;
        int unsigned sw;
        int unsigned sh;
        int unsigned sx;
        int unsigned sy;
        int unsigned luma;
        logic [nns_pkg::WORD_W-1:0] word;
        px = '0;
        if (dx >= reg_dst_w || dy >= reg_dst_h)
        begin
            px.oob = 1'b1;
            return px;
        end
        sw = eff_dim(32'(reg_src_w), SRC_MAX_W);
        sh = eff_dim(32'(reg_src_h), SRC_MAX_H);
        sx = (32'(dx) * sw) / 32'(reg_dst_w);
        sy = (32'(dy) * sh) / 32'(reg_dst_h);
        word = src_frame[sy * SRC_MAX_W + sx];
        px.red   = word[7:0];
        px.green = word[15:8];
        px.blue  = word[23:16];
        px.alpha = word[31:24];
        if (reg_gray)
        begin
            luma = (LUMA_COEF_R * 32'(px.red) + LUMA_COEF_G * 32'(px.green)
                    + LUMA_COEF_B * 32'(px.blue)) >> 16;
            px.red   = luma[7:0];
            px.green = luma[7:0];
            px.blue  = luma[7:0];
        end
        return px;
    endfunction

    // Write a source pixel into the mirror; drop it when outside the source size
    function automatic void store_load(input logic [nns_pkg::COORD_W-1:0] x,
                                       input logic [nns_pkg::COORD_W-1:0] y,
                                       input logic [nns_pkg::WORD_W-1:0] word);
        int unsigned addr;
        if (32'(x) < eff_dim(32'(reg_src_w), SRC_MAX_W)
            && 32'(y) < eff_dim(32'(reg_src_h), SRC_MAX_H))
        begin
            addr = 32'(y) * SRC_MAX_W + 32'(x);
            src_frame[addr] = word;
            src_written[addr] = 1'b1;
        end
    endfunction

    function automatic dir_row_t reg_row(input logic [nns_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [nns_pkg::CFG_DATA_W-1:0] data);
        dir_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic dir_row_t load_row(input int unsigned x, input int unsigned y,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] a);
        dir_row_t row;
        row = '0;
        row.kind = ROW_BEAT;
        row.beat_cmd = nns_pkg::CMD_LOAD;
        row.x = nns_pkg::COORD_W'(x);
        row.y = nns_pkg::COORD_W'(y);
        row.pixel = {a, b, g, r};
        return row;
    endfunction

    function automatic dir_row_t fetch_row(input int unsigned x, input int unsigned y);
        dir_row_t row;
        row = '0;
        row.kind = ROW_BEAT;
        row.beat_cmd = nns_pkg::CMD_FETCH;
        row.x = nns_pkg::COORD_W'(x);
        row.y = nns_pkg::COORD_W'(y);
        return row;
    endfunction

    function automatic dir_row_t typed_row(input int unsigned x, input int unsigned y,
                                           input scaled_pixel_t want);
        dir_row_t row;
        row = fetch_row(x, y);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    // Coordinate below limit, leaning toward both edges
    function automatic int unsigned pick_coord(input int unsigned limit);
        case ($urandom_range(7))
            0: return 0;
            1: return limit - 1;
            default: return $urandom_range(limit - 1);
        endcase
    endfunction

    // Coordinate at or past limit, the boundary itself now and then
    function automatic int unsigned pick_outside(input int unsigned limit);
        if ($urandom_range(3) == 0)
            return limit;
        return $urandom_range(COORD_TOP, limit);
    endfunction

    // Present one beat, hold it until accepted, then update the prediction
    task automatic send_beat(input logic c, input logic [nns_pkg::COORD_W-1:0] x,
                             input logic [nns_pkg::COORD_W-1:0] y,
                             input logic [nns_pkg::WORD_W-1:0] word,
                             input logic typed, input scaled_pixel_t want);
        scaled_pixel_t expected;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        pos_x    <= x;
        pos_y    <= y;
        in_red   <= word[7:0];
        in_green <= word[15:8];
        in_blue  <= word[23:16];
        in_alpha <= word[31:24];
        do @(posedge clk); while (!in_ready);
        if (c == nns_pkg::CMD_FETCH)
        begin
            expected = typed ? want : resample_pixel(x, y);
            pending_pixels.push_back(expected);
            n_fetches++;
            if (expected.oob)
                n_oob++;
        end
        else
        begin
            store_load(x, y, word);
            n_loads++;
        end
    endtask

    // Keep cfg_valid high across back-to-back writes; the caller lowers it
    task automatic write_reg(input logic [nns_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nns_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            nns_pkg::CFG_SRC_WIDTH:  reg_src_w = data[nns_pkg::SRC_DIM_W-1:0];
            nns_pkg::CFG_SRC_HEIGHT: reg_src_h = data[nns_pkg::SRC_DIM_W-1:0];
            nns_pkg::CFG_DST_WIDTH:  reg_dst_w = data[nns_pkg::DST_DIM_W-1:0];
            nns_pkg::CFG_DST_HEIGHT: reg_dst_h = data[nns_pkg::DST_DIM_W-1:0];
            nns_pkg::CFG_GRAY_MODE:  reg_gray  = data[0];
            default: ;
        endcase
        n_reg_writes++;
    endtask

    // Stop sending, wait out every pending result, then let the pipe settle
    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_pixels.size() != 0);
        repeat (settle + 1) @(posedge clk);
    endtask

    // One randomized phase under a fixed setup and idle profile
    task automatic run_random_phase(input logic [nns_pkg::CFG_DATA_W-1:0] sw_data,
                                    input logic [nns_pkg::CFG_DATA_W-1:0] sh_data,
                                    input logic [nns_pkg::CFG_DATA_W-1:0] dw_data,
                                    input logic [nns_pkg::CFG_DATA_W-1:0] dh_data,
                                    input logic [nns_pkg::CFG_DATA_W-1:0] gray_data,
                                    input int unsigned send_pct,
                                    input int unsigned stall,
                                    input int unsigned n_beats);
        int unsigned counted;
        int unsigned sel;
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
        int unsigned dx;
        int unsigned dy;
        int unsigned sx;
        int unsigned sy;
        drain_results(CFG_SETTLE_CYCLES);
        write_reg(nns_pkg::CFG_SRC_WIDTH, sw_data);
        write_reg(nns_pkg::CFG_SRC_HEIGHT, sh_data);
        write_reg(nns_pkg::CFG_DST_WIDTH, dw_data);
        write_reg(nns_pkg::CFG_DST_HEIGHT, dh_data);
        write_reg(nns_pkg::CFG_GRAY_MODE, gray_data);
        cfg_valid <= 1'b0;
        send_idle_pct = send_pct;
        stall_pct = stall;
        n_phases++;
        sw = eff_dim(32'(reg_src_w), SRC_MAX_W);
        sh = eff_dim(32'(reg_src_h), SRC_MAX_H);
        dw = 32'(reg_dst_w);
        dh = 32'(reg_dst_h);
        counted = 0;
        while (counted < n_beats)
        begin
            sel = $urandom_range(99);
            if (sel < 55 && dw != 0 && dh != 0)
            begin
                // Well-formed fetch; load its source pixel first if never written
                dx = pick_coord(dw);
                dy = pick_coord(dh);
                sx = (dx * sw) / dw;
                sy = (dy * sh) / dh;
                if (!src_written[sy * SRC_MAX_W + sx])
                begin
                    send_beat(nns_pkg::CMD_LOAD, nns_pkg::COORD_W'(sx),
                              nns_pkg::COORD_W'(sy), $urandom, 1'b0, '0);
                    counted++;
                end
                send_beat(nns_pkg::CMD_FETCH, nns_pkg::COORD_W'(dx), nns_pkg::COORD_W'(dy),
                          $urandom, 1'b0, '0);
                counted++;
            end
            else if (sel < 75)
            begin
                send_beat(nns_pkg::CMD_LOAD, nns_pkg::COORD_W'(pick_coord(sw)),
                          nns_pkg::COORD_W'(pick_coord(sh)), $urandom, 1'b0, '0);
                counted++;
            end
            else if (sel < 88)
            begin
                // Fetch past the destination edge on one axis
                if ($urandom_range(1) == 1)
                begin
                    dx = pick_outside(dw);
                    dy = $urandom_range(COORD_TOP);
                end
                else
                begin
                    dx = $urandom_range(COORD_TOP);
                    dy = pick_outside(dh);
                end
                send_beat(nns_pkg::CMD_FETCH, nns_pkg::COORD_W'(dx), nns_pkg::COORD_W'(dy),
                          $urandom, 1'b0, '0);
                counted++;
            end
            else
            begin
                // Load past the source edge: dropped, not counted
                if ($urandom_range(1) == 1)
                begin
                    dx = pick_outside(sw);
                    dy = $urandom_range(COORD_TOP);
                end
                else
                begin
                    dx = $urandom_range(COORD_TOP);
                    dy = pick_outside(sh);
                end
                send_beat(nns_pkg::CMD_LOAD, nns_pkg::COORD_W'(dx), nns_pkg::COORD_W'(dy),
                          $urandom, 1'b0, '0);
            end
            if ($urandom_range(99) < 2)
                drain_results(0);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Receiver: stall at the phase's rate
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Score each result beat against the oldest expectation
    always @(posedge clk)
    begin : take_result
        scaled_pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t ns: result with nothing expected, got r=%0d g=%0d b=%0d",
                         $time, out_red, out_green, out_blue);
                $display("%0t ns: and a=%0d err=%0d", $time, out_alpha, range_error);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("out_red", 32'(want.red), 32'(out_red));
                check_field("out_green", 32'(want.green), 32'(out_green));
                check_field("out_blue", 32'(want.blue), 32'(out_blue));
                check_field("out_alpha", 32'(want.alpha), 32'(out_alpha));
                check_field("range_error", 32'(want.oob), 32'(range_error));
            end
        end
    end

    initial
    begin : main
        logic cfg_burst;
        cfg_burst = 1'b0;

        // Directed table: corners, dropped loads, edges, gray extremes, size clamps
        dir_rows.push_back(load_row(0, 0, 8'hFF, 8'h00, 8'h00, 8'h80));
        dir_rows.push_back(typed_row(0, 0, {8'hFF, 8'h00, 8'h00, 8'h80, 1'b0}));
        dir_rows.push_back(load_row(255, 255, 8'h01, 8'h02, 8'h03, 8'hFF));
        dir_rows.push_back(typed_row(255, 255, {8'h01, 8'h02, 8'h03, 8'hFF, 1'b0}));
        dir_rows.push_back(load_row(0, 1, 8'h11, 8'h22, 8'h33, 8'h44));
        dir_rows.push_back(load_row(256, 0, 8'hAA, 8'hBB, 8'hCC, 8'hDD));
        dir_rows.push_back(typed_row(0, 1, {8'h11, 8'h22, 8'h33, 8'h44, 1'b0}));
        dir_rows.push_back(load_row(COORD_TOP, COORD_TOP, 8'h55, 8'h66, 8'h77, 8'h88));
        dir_rows.push_back(typed_row(256, 0, OOB_PIXEL));
        dir_rows.push_back(typed_row(0, 256, OOB_PIXEL));
        dir_rows.push_back(typed_row(COORD_TOP, COORD_TOP, OOB_PIXEL));
        dir_rows.push_back(load_row(1, 0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        dir_rows.push_back(reg_row(nns_pkg::CFG_GRAY_MODE, 15'h0001));
        dir_rows.push_back(typed_row(1, 0, {8'hFE, 8'hFE, 8'hFE, 8'h00, 1'b0}));
        dir_rows.push_back(fetch_row(0, 0));
        dir_rows.push_back(reg_row(CFG_UNUSED_LO, 15'h7FFF));
        dir_rows.push_back(reg_row(CFG_UNUSED_HI, 15'h0000));
        dir_rows.push_back(fetch_row(255, 255));
        // Zero source size clamps to one pixel
        dir_rows.push_back(reg_row(nns_pkg::CFG_SRC_WIDTH, 15'd0));
        dir_rows.push_back(reg_row(nns_pkg::CFG_SRC_HEIGHT, 15'd0));
        dir_rows.push_back(reg_row(nns_pkg::CFG_DST_WIDTH, 15'd1));
        dir_rows.push_back(reg_row(nns_pkg::CFG_DST_HEIGHT, 15'd1));
        dir_rows.push_back(reg_row(nns_pkg::CFG_GRAY_MODE, 15'h7FFE));
        dir_rows.push_back(load_row(1, 0, 8'h00, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(typed_row(0, 0, {8'hFF, 8'h00, 8'h00, 8'h80, 1'b0}));
        dir_rows.push_back(typed_row(1, 0, OOB_PIXEL));
        // Oversized source clamps to the store; zero destination width flags all
        dir_rows.push_back(reg_row(nns_pkg::CFG_SRC_WIDTH, 15'h7F00));
        dir_rows.push_back(reg_row(nns_pkg::CFG_SRC_HEIGHT, 15'h01FF));
        dir_rows.push_back(reg_row(nns_pkg::CFG_DST_WIDTH, 15'd0));
        dir_rows.push_back(reg_row(nns_pkg::CFG_DST_HEIGHT, 15'd32767));
        dir_rows.push_back(typed_row(0, 0, OOB_PIXEL));
        dir_rows.push_back(reg_row(nns_pkg::CFG_DST_WIDTH, 15'd32767));
        dir_rows.push_back(fetch_row(32766, 32766));
        dir_rows.push_back(typed_row(0, 0, {8'hFF, 8'h00, 8'h00, 8'h80, 1'b0}));
        dir_rows.push_back(fetch_row(128, 0));

        // Hold reset, then release it for good
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                if (!cfg_burst)
                begin
                    drain_results(CFG_SETTLE_CYCLES);
                    cfg_burst = 1'b1;
                end
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            end
            else
            begin
                if (cfg_burst)
                begin
                    cfg_valid <= 1'b0;
                    cfg_burst = 1'b0;
                end
                send_beat(dir_rows[i].beat_cmd, dir_rows[i].x, dir_rows[i].y,
                          dir_rows[i].pixel, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random phases: src w/h, dst w/h, gray, sender idle %, receiver stall %, beats
        run_random_phase(15'd256, 15'd256, 15'd256, 15'd256, 15'd0, 0, 0, 130);
        run_random_phase(15'd16, 15'd12, 15'd64, 15'd48, 15'd1, 76, 0, 120);
        run_random_phase(15'd200, 15'd150, 15'd20, 15'd15, 15'd0, 0, 76, 120);
        run_random_phase(15'd1, 15'd1, 15'd32767, 15'd32767, 15'd1, 6, 6, 120);
        run_random_phase(15'd511, 15'd0, 15'd1, 15'd1, 15'd0, 0, 0, 100);
        run_random_phase(15'd37, 15'd256, 15'd32767, 15'd5, 15'h7FFF, 76, 0, 120);
        run_random_phase(15'd256, 15'd256, 15'd0, 15'd100, 15'd0, 0, 76, 40);
        run_random_phase(15'd100, 15'd200, 15'd300, 15'd7, 15'd1, 6, 6, 130);

        drain_results(END_SETTLE_CYCLES);

        $display("Covered %0d loads and %0d fetches, %0d of them past the destination edge.",
                 n_loads, n_fetches, n_oob);
        $display("Directed table of %0d rows, %0d register writes, %0d random phases.",
                 dir_rows.size(), n_reg_writes, n_phases);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t ns: timeout with %0d results outstanding", $time, pending_pixels.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
